// ----- hw/rtl/lad_pkg.sv -----
// ============================================================================
// lad_pkg
// Shared widths, pipeline latencies and helpers for the look-at view matrix.
// ============================================================================
`default_nettype none

package lad_pkg;

    // Q16.16 data word and the fractional bit count.
    localparam int Q_W         = 32;
    localparam int FRAC_W      = 16;

    // Difference vector, target minus eye, is exact in one extra bit.
    localparam int D_W         = Q_W + 1;

    // A normalized axis component lies in [-2^16, 2^16].
    localparam int AXIS_W      = FRAC_W + 2;

    // Cross product widths: axis x hint and axis x axis.
    localparam int RC_W        = AXIS_W + Q_W + 1;
    localparam int UC_W        = 2 * AXIS_W + 1;

    // Dot product of an axis with the eye point.
    localparam int DOT_W       = AXIS_W + Q_W + 1;

    // Normalizer internals: scaled magnitudes, squared sum, root, quotient.
    localparam int MAG_W       = 30;
    localparam int SQ_W        = 2 * MAG_W + 2;
    localparam int LEN_W       = SQ_W / 2;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int NUM_W       = MAG_W + FRAC_W + 1;

    localparam int SQRT_STAGES = LEN_W;
    localparam int DIV_STAGES  = QUO_W;

    // Front end (abs, leading one, shift, square, sum) is five stages.
    localparam int NORM_LAT    = 5 + SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam int CROSS_LAT   = 2;
    localparam int OFFS_LAT    = 3;

    // Sign-extends an axis component to a Q16.16 word.
    function automatic logic signed [Q_W-1:0] axis_to_q(input logic signed [AXIS_W-1:0] v);
        return {{(Q_W - AXIS_W){v[AXIS_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/look_at_view_matrix.sv -----
// ============================================================================
// look_at_view_matrix
// Right-handed look-at view matrix in signed Q16.16, fully pipelined.
// ============================================================================
//
//   Channel   Direction   Handshake              Payload
//   -------   ---------   --------------------   -------------------------------
//   input     sink        i_valid / o_stall      eye, target, up hint (9 x Q16.16)
//   output    source      o_valid / i_stall      12 matrix entries (12 x Q16.16)
//
// One request enters per cycle while the output is not stalled. Most of the
// pipeline depth lies in the three normalizers in series, each with a 31-stage
// square root and a 17-stage divider.
// Reset clears only the valid bits of the stages; payload registers are not reset.
// A stall on the output holds a waiting result and freezes every stage at once,
// so the input stalls exactly while a result waits and i_stall is high.
//
// Flow: front = norm(target - eye); right = norm(front x up hint);
// up = norm(right x front). The offsets use the negated right and up axes
// and the front axis directly, so one dot-product unit design serves all three.
// Side payload (eye, hint, finished axes) travels on delay lines that share
// the common enable with the arithmetic stages.
// ============================================================================
`default_nettype none

module look_at_view_matrix
    import lad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [Q_W-1:0] i_eye_x,
    input  logic signed [Q_W-1:0] i_eye_y,
    input  logic signed [Q_W-1:0] i_eye_z,
    input  logic signed [Q_W-1:0] i_target_x,
    input  logic signed [Q_W-1:0] i_target_y,
    input  logic signed [Q_W-1:0] i_target_z,
    input  logic signed [Q_W-1:0] i_up_hint_x,
    input  logic signed [Q_W-1:0] i_up_hint_y,
    input  logic signed [Q_W-1:0] i_up_hint_z,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [Q_W-1:0] o_right_x,
    output logic signed [Q_W-1:0] o_right_y,
    output logic signed [Q_W-1:0] o_right_z,
    output logic signed [Q_W-1:0] o_right_offset,
    output logic signed [Q_W-1:0] o_upaxis_x,
    output logic signed [Q_W-1:0] o_upaxis_y,
    output logic signed [Q_W-1:0] o_upaxis_z,
    output logic signed [Q_W-1:0] o_upaxis_offset,
    output logic signed [Q_W-1:0] o_back_x,
    output logic signed [Q_W-1:0] o_back_y,
    output logic signed [Q_W-1:0] o_back_z,
    output logic signed [Q_W-1:0] o_front_offset
);

    // The whole pipeline advances unless a finished result is being held.
    logic en;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Entry stage: the difference vector, eye and hint are registered.
    logic signed [D_W-1:0] r_d    [3];
    logic signed [Q_W-1:0] r_eye  [3];
    logic signed [Q_W-1:0] r_hint [3];
    logic                  r_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]    <= {i_target_x[Q_W-1], i_target_x} - {i_eye_x[Q_W-1], i_eye_x};
            r_d[1]    <= {i_target_y[Q_W-1], i_target_y} - {i_eye_y[Q_W-1], i_eye_y};
            r_d[2]    <= {i_target_z[Q_W-1], i_target_z} - {i_eye_z[Q_W-1], i_eye_z};
            r_eye[0]  <= i_eye_x;
            r_eye[1]  <= i_eye_y;
            r_eye[2]  <= i_eye_z;
            r_hint[0] <= i_up_hint_x;
            r_hint[1] <= i_up_hint_y;
            r_hint[2] <= i_up_hint_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    // Front axis.
    logic                     front_vld;
    logic signed [AXIS_W-1:0] front [3];

    lad_norm #(.W(D_W)) u_norm_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld),
        .i_vec   (r_d),
        .o_valid (front_vld),
        .o_vec   (front)
    );

    // Hint and eye catch up with the front axis.
    logic [3*Q_W-1:0]      hint_pk;
    logic signed [Q_W-1:0] hint_d [3];
    logic [3*Q_W-1:0]      eye_a_pk;
    logic signed [Q_W-1:0] eye_a [3];

    lad_delay #(.W(3 * Q_W), .N(NORM_LAT)) u_dly_hint (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_hint[0], r_hint[1], r_hint[2]}),
        .o_d   (hint_pk)
    );

    lad_delay #(.W(3 * Q_W), .N(NORM_LAT)) u_dly_eye_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_eye[0], r_eye[1], r_eye[2]}),
        .o_d   (eye_a_pk)
    );

    assign {hint_d[0], hint_d[1], hint_d[2]} = hint_pk;
    assign {eye_a[0], eye_a[1], eye_a[2]}    = eye_a_pk;

    // Right axis: normalized front x hint.
    logic                   rc_vld;
    logic signed [RC_W-1:0] rc [3];

    lad_cross #(.AW(AXIS_W), .BW(Q_W)) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_a     (front),
        .i_b     (hint_d),
        .o_valid (rc_vld),
        .o_c     (rc)
    );

    logic                     right_vld;
    logic signed [AXIS_W-1:0] right [3];

    lad_norm #(.W(RC_W)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rc_vld),
        .i_vec   (rc),
        .o_valid (right_vld),
        .o_vec   (right)
    );

    // Front and eye catch up with the right axis.
    logic [3*AXIS_W-1:0]      front_b_pk;
    logic signed [AXIS_W-1:0] front_b [3];
    logic [3*Q_W-1:0]         eye_b_pk;
    logic signed [Q_W-1:0]    eye_b [3];

    lad_delay #(.W(3 * AXIS_W), .N(NORM_LAT + CROSS_LAT)) u_dly_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({front[0], front[1], front[2]}),
        .o_d   (front_b_pk)
    );

    lad_delay #(.W(3 * Q_W), .N(NORM_LAT + CROSS_LAT)) u_dly_eye_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (eye_a_pk),
        .o_d   (eye_b_pk)
    );

    assign {front_b[0], front_b[1], front_b[2]} = front_b_pk;
    assign {eye_b[0], eye_b[1], eye_b[2]}       = eye_b_pk;

    // True up axis: normalized right x front.
    logic                   uc_vld;
    logic signed [UC_W-1:0] uc [3];

    lad_cross #(.AW(AXIS_W), .BW(AXIS_W)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (right_vld),
        .i_a     (right),
        .i_b     (front_b),
        .o_valid (uc_vld),
        .o_c     (uc)
    );

    logic                     up_vld;
    logic signed [AXIS_W-1:0] up [3];

    lad_norm #(.W(UC_W)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (uc_vld),
        .i_vec   (uc),
        .o_valid (up_vld),
        .o_vec   (up)
    );

    logic [3*Q_W-1:0]      eye_c_pk;
    logic signed [Q_W-1:0] eye_c [3];

    lad_delay #(.W(3 * Q_W), .N(NORM_LAT + CROSS_LAT)) u_dly_eye_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (eye_b_pk),
        .o_d   (eye_c_pk)
    );

    assign {eye_c[0], eye_c[1], eye_c[2]} = eye_c_pk;

    // Negated axes: back for the matrix, right and up for their offsets.
    logic signed [AXIS_W-1:0] back    [3];
    logic signed [AXIS_W-1:0] right_n [3];
    logic signed [AXIS_W-1:0] up_n    [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            back[j]    = -front[j];
            right_n[j] = -right[j];
            up_n[j]    = -up[j];
        end
    end

    // Offsets. The up offset sets the output valid; the others are realigned.
    logic                  front_off_vld_unused;
    logic                  right_off_vld_unused;
    logic signed [Q_W-1:0] front_off;
    logic signed [Q_W-1:0] right_off;

    lad_offset u_off_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (front_vld),
        .i_axis   (front),
        .i_eye    (eye_a),
        .o_valid  (front_off_vld_unused),
        .o_offset (front_off)
    );

    lad_offset u_off_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (right_vld),
        .i_axis   (right_n),
        .i_eye    (eye_b),
        .o_valid  (right_off_vld_unused),
        .o_offset (right_off)
    );

    lad_offset u_off_up (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (up_vld),
        .i_axis   (up_n),
        .i_eye    (eye_c),
        .o_valid  (o_valid),
        .o_offset (o_upaxis_offset)
    );

    // Output alignment lines; their last taps are the output registers.
    // An offset leaves its unit after its axis, behind the unit's product, sum and
    // rounding registers, so the offset lines are shorter than the axis lines by them.
    localparam int BACK_N  = 2 * (NORM_LAT + CROSS_LAT) + OFFS_LAT;
    localparam int RIGHT_N = NORM_LAT + CROSS_LAT + OFFS_LAT;

    logic [3*AXIS_W-1:0]      back_pk;
    logic [3*AXIS_W-1:0]      right_pk;
    logic [3*AXIS_W-1:0]      up_pk;
    logic signed [AXIS_W-1:0] back_o  [3];
    logic signed [AXIS_W-1:0] right_o [3];
    logic signed [AXIS_W-1:0] up_o    [3];

    lad_delay #(.W(3 * AXIS_W), .N(BACK_N)) u_dly_back_out (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({back[0], back[1], back[2]}),
        .o_d   (back_pk)
    );

    lad_delay #(.W(Q_W), .N(BACK_N - OFFS_LAT)) u_dly_front_off (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (front_off),
        .o_d   (o_front_offset)
    );

    lad_delay #(.W(3 * AXIS_W), .N(RIGHT_N)) u_dly_right_out (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({right[0], right[1], right[2]}),
        .o_d   (right_pk)
    );

    lad_delay #(.W(Q_W), .N(RIGHT_N - OFFS_LAT)) u_dly_right_off (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (right_off),
        .o_d   (o_right_offset)
    );

    lad_delay #(.W(3 * AXIS_W), .N(OFFS_LAT)) u_dly_up_out (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({up[0], up[1], up[2]}),
        .o_d   (up_pk)
    );

    assign {back_o[0], back_o[1], back_o[2]}    = back_pk;
    assign {right_o[0], right_o[1], right_o[2]} = right_pk;
    assign {up_o[0], up_o[1], up_o[2]}          = up_pk;

    assign o_right_x  = axis_to_q(right_o[0]);
    assign o_right_y  = axis_to_q(right_o[1]);
    assign o_right_z  = axis_to_q(right_o[2]);
    assign o_upaxis_x = axis_to_q(up_o[0]);
    assign o_upaxis_y = axis_to_q(up_o[1]);
    assign o_upaxis_z = axis_to_q(up_o[2]);
    assign o_back_x   = axis_to_q(back_o[0]);
    assign o_back_y   = axis_to_q(back_o[1]);
    assign o_back_z   = axis_to_q(back_o[2]);

endmodule

`default_nettype wire

// ----- hw/rtl/lad_delay.sv -----
// ============================================================================
// lad_delay
// Enabled shift line that carries payload alongside the arithmetic stages.
// ============================================================================
`default_nettype none

module lad_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/lad_isqrt.sv -----
// ============================================================================
// lad_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ============================================================================
`default_nettype none

module lad_isqrt
    import lad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_n,
    output logic [LEN_W-1:0]  o_root
);

    logic [SQ_W-1:0]  r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0] r_root [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam int BIT = LEN_W - 1 - k;

        logic [SQ_W-1:0]  src_rem;
        logic [LEN_W-1:0] src_root;
        logic [SQ_W:0]    trial;
        logic             fits;

        if (k == 0) begin : g_first
            assign src_rem  = i_n;
            assign src_root = '0;
        end else begin : g_next
            assign src_rem  = r_rem[k-1];
            assign src_root = r_root[k-1];
        end

        // Trial term is (2 * root + 2^bit) * 2^bit for the bits decided so far.
        assign trial = ((SQ_W+1)'(src_root) << (BIT + 1)) + ((SQ_W+1)'(1) << (2 * BIT));
        assign fits  = ({1'b0, src_rem} >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= fits ? (src_rem - trial[SQ_W-1:0]) : src_rem;
                r_root[k] <= fits ? (src_root | (LEN_W'(1) << BIT)) : src_root;
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/lad_norm.sv -----
// ============================================================================
// lad_norm
// Pipelined vector normalizer: scale, square-sum, root and divide per lane.
// ============================================================================
`default_nettype none

module lad_norm
    import lad_pkg::*;
#(
    parameter int W = D_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [W-1:0]      i_vec [3],
    output logic                     o_valid,
    output logic signed [AXIS_W-1:0] o_vec [3]
);

    localparam int MSB_W = $clog2(W);
    localparam logic [MSB_W-1:0] TGT = MSB_W'(MAG_W - 1);

    logic [NORM_LAT-1:0] r_vld;

    // Stage 1: sign and magnitude, largest magnitude.
    logic [W-1:0] n1_mag [3];
    logic [W-1:0] n1_max;
    logic [W-1:0] r1_mag [3];
    logic [2:0]   r1_neg;
    logic [W-1:0] r1_max;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n1_mag[j] = i_vec[j][W-1] ? (~i_vec[j] + W'(1)) : i_vec[j];
        end
        n1_max = n1_mag[0];
        if (n1_mag[1] > n1_max) begin
            n1_max = n1_mag[1];
        end
        if (n1_mag[2] > n1_max) begin
            n1_max = n1_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_mag[j] <= n1_mag[j];
                r1_neg[j] <= i_vec[j][W-1];
            end
            r1_max <= n1_max;
        end
    end

    // Stage 2: position of the leading one of the largest magnitude.
    logic [MSB_W-1:0] n2_msb;
    logic [MSB_W-1:0] r2_msb;
    logic [W-1:0]     r2_mag [3];
    logic [2:0]       r2_neg;
    logic             r2_zero;

    always_comb begin
        n2_msb = '0;
        for (int b = 0; b < W; b++) begin
            if (r1_max[b]) begin
                n2_msb = MSB_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_msb  <= n2_msb;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_max == '0);
        end
    end

    // Stage 3: shift all magnitudes so the largest lands in [2^29, 2^30).
    logic [W-1:0]     n3_sh  [3];
    logic [MAG_W-1:0] r3_mag [3];
    logic [2:0]       r3_neg;
    logic             r3_zero;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n3_sh[j] = (r2_msb >= TGT) ? (r2_mag[j] >> (r2_msb - TGT))
                                       : (r2_mag[j] << (TGT - r2_msb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r3_mag[j] <= n3_sh[j][MAG_W-1:0];
            end
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
        end
    end

    // Stages 4 and 5: squares, then their sum.
    logic [2*MAG_W-1:0] r4_sq [3];
    logic [SQ_W-1:0]    r5_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r4_sq[j] <= r3_mag[j] * r3_mag[j];
            end
            r5_sum <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
        end
    end

    logic [LEN_W-1:0] len;

    lad_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_n    (r5_sum),
        .o_root (len)
    );

    // Magnitudes and flags ride alongside the square-sum and root stages.
    logic [3*MAG_W+3:0] side_d;
    logic [MAG_W-1:0]   dmag [3];
    logic [2:0]         dneg;
    logic               dzero;

    lad_delay #(.W(3 * MAG_W + 4), .N(2 + SQRT_STAGES)) u_side (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r3_mag[0], r3_mag[1], r3_mag[2], r3_neg, r3_zero}),
        .o_d   (side_d)
    );

    assign {dmag[0], dmag[1], dmag[2], dneg, dzero} = side_d;

    logic [3:0] flag_d;

    lad_delay #(.W(4), .N(1 + DIV_STAGES)) u_flag (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({dneg, dzero}),
        .o_d   (flag_d)
    );

    // Division setup: (mag * 2^16 + len / 2), divided by len below.
    logic [NUM_W-1:0] r0_num [3];
    logic [LEN_W-1:0] r0_len;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r0_num[j] <= (NUM_W'(dmag[j]) << FRAC_W) + NUM_W'(len >> 1);
            end
            r0_len <= len;
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes.
    logic [NUM_W-1:0] r_rem [DIV_STAGES][3];
    logic [QUO_W-1:0] r_q   [DIV_STAGES][3];
    logic [LEN_W-1:0] r_dl  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int BIT = QUO_W - 1 - k;

        logic [NUM_W-1:0] src_rem [3];
        logic [QUO_W-1:0] src_q   [3];
        logic [LEN_W-1:0] src_len;
        logic [NUM_W-1:0] dv;
        logic [2:0]       ge;

        if (k == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    src_rem[j] = r0_num[j];
                    src_q[j]   = '0;
                end
            end
            assign src_len = r0_len;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_q   = r_q[k-1];
            assign src_len = r_dl[k-1];
        end

        assign dv = NUM_W'(src_len) << BIT;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                ge[j] = (src_rem[j] >= dv);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    r_rem[k][j] <= ge[j] ? (src_rem[j] - dv) : src_rem[j];
                    r_q[k][j]   <= {src_q[j][QUO_W-2:0], ge[j]};
                end
                r_dl[k] <= src_len;
            end
        end
    end

    // Final stage: restore signs; a zero-length vector gives zeros.
    // Flag bit 0 is the zero flag and bit j+1 is the sign of lane j.
    logic signed [AXIS_W-1:0] r_out [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                if (flag_d[0]) begin
                    r_out[j] <= '0;
                end else if (flag_d[j+1]) begin
                    r_out[j] <= -$signed({1'b0, r_q[DIV_STAGES-1][j]});
                end else begin
                    r_out[j] <= $signed({1'b0, r_q[DIV_STAGES-1][j]});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[NORM_LAT-1];
    assign o_vec   = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/lad_cross.sv -----
// ============================================================================
// lad_cross
// Two-stage cross product: six products, then three differences.
// ============================================================================
`default_nettype none

module lad_cross
    import lad_pkg::*;
#(
    parameter int AW = AXIS_W,
    parameter int BW = Q_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [AW-1:0]    i_a [3],
    input  logic signed [BW-1:0]    i_b [3],
    output logic                    o_valid,
    output logic signed [AW+BW:0]   o_c [3]
);

    logic signed [AW+BW-1:0] r_p [6];
    logic signed [AW+BW:0]   r_c [3];
    logic [1:0]              r_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_a[1] * i_b[2];
            r_p[1] <= i_a[2] * i_b[1];
            r_p[2] <= i_a[2] * i_b[0];
            r_p[3] <= i_a[0] * i_b[2];
            r_p[4] <= i_a[0] * i_b[1];
            r_p[5] <= i_a[1] * i_b[0];
            for (int j = 0; j < 3; j++) begin
                r_c[j] <= (AW+BW+1)'(r_p[2*j]) - (AW+BW+1)'(r_p[2*j+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    assign o_valid = r_vld[1];
    assign o_c     = r_c;

endmodule

`default_nettype wire

// ----- hw/rtl/lad_offset.sv -----
// ============================================================================
// lad_offset
// Axis dot eye, rounded half away from zero to Q16.16 and saturated.
// ============================================================================
`default_nettype none

module lad_offset
    import lad_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [AXIS_W-1:0] i_axis [3],
    input  logic signed [Q_W-1:0]    i_eye  [3],
    output logic                     o_valid,
    output logic signed [Q_W-1:0]    o_offset
);

    localparam int RND_W = DOT_W - FRAC_W + 1;
    localparam logic [RND_W-1:0] POS_LIM = RND_W'(64'h7FFF_FFFF);
    localparam logic [RND_W-1:0] NEG_LIM = RND_W'(64'h8000_0000);

    logic signed [AXIS_W+Q_W-1:0] r_p [3];
    logic signed [DOT_W-1:0]      r_sum;
    logic signed [Q_W-1:0]        r_off;
    logic [2:0]                   r_vld;

    logic             neg;
    logic [DOT_W-1:0] mag;
    logic [RND_W-1:0] rnd;
    logic [Q_W-1:0]   low;

    always_comb begin
        neg = r_sum[DOT_W-1];
        mag = neg ? (~r_sum + DOT_W'(1)) : r_sum;
        rnd = RND_W'(({1'b0, mag} + (DOT_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W);
        low = rnd[Q_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p[j] <= i_axis[j] * i_eye[j];
            end
            r_sum <= DOT_W'(r_p[0]) + DOT_W'(r_p[1]) + DOT_W'(r_p[2]);
            if (neg) begin
                r_off <= (rnd > NEG_LIM) ? $signed(NEG_LIM[Q_W-1:0]) : $signed(~low + Q_W'(1));
            end else begin
                r_off <= (rnd > POS_LIM) ? $signed(POS_LIM[Q_W-1:0]) : $signed(low);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid  = r_vld[2];
    assign o_offset = r_off;

endmodule

`default_nettype wire

// ----- hw/rtl/lad_chk.sv -----
// ============================================================================
// lad_chk
// Port-level checks of the look-at view matrix, bound to the top level.
// ============================================================================
`default_nettype none

module lad_chk
    import lad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic signed [Q_W-1:0] i_eye_x,
    input  logic signed [Q_W-1:0] i_eye_y,
    input  logic signed [Q_W-1:0] i_eye_z,
    input  logic signed [Q_W-1:0] i_target_x,
    input  logic signed [Q_W-1:0] i_target_y,
    input  logic signed [Q_W-1:0] i_target_z,
    input  logic signed [Q_W-1:0] i_up_hint_x,
    input  logic signed [Q_W-1:0] i_up_hint_y,
    input  logic signed [Q_W-1:0] i_up_hint_z,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic signed [Q_W-1:0] o_right_x,
    input  logic signed [Q_W-1:0] o_right_y,
    input  logic signed [Q_W-1:0] o_right_z,
    input  logic signed [Q_W-1:0] o_right_offset,
    input  logic signed [Q_W-1:0] o_upaxis_x,
    input  logic signed [Q_W-1:0] o_upaxis_y,
    input  logic signed [Q_W-1:0] o_upaxis_z,
    input  logic signed [Q_W-1:0] o_upaxis_offset,
    input  logic signed [Q_W-1:0] o_back_x,
    input  logic signed [Q_W-1:0] o_back_y,
    input  logic signed [Q_W-1:0] o_back_z,
    input  logic signed [Q_W-1:0] o_front_offset
);

    localparam logic signed [Q_W-1:0] ONE  = Q_W'(1 << FRAC_W);
    localparam logic signed [Q_W-1:0] MONE = -ONE;

    logic back_zero;
    logic right_zero;

    assign back_zero  = (o_back_x == '0) && (o_back_y == '0) && (o_back_z == '0);
    assign right_zero = (o_right_x == '0) && (o_right_y == '0) && (o_right_z == '0);

    // The input is held back only while a finished result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // A held result keeps its values.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_back_x) && $stable(o_right_offset)
                                  && $stable(o_upaxis_z)))
        else $error("held result changed");

    // Normalized components stay within one unit.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_back_x >= MONE && o_back_x <= ONE && o_right_y >= MONE
                     && o_right_y <= ONE && o_upaxis_z >= MONE && o_upaxis_z <= ONE))
        else $error("axis component beyond one unit");

    // A degenerate front axis zeroes the right axis, up x, and the front and up offsets.
    a_front_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && back_zero) |-> (right_zero && o_front_offset == '0
                                    && o_upaxis_x == '0 && o_upaxis_offset == '0))
        else $error("zero front axis gave nonzero entries");

    // A degenerate right axis zeroes up y and the right and up offsets.
    a_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && right_zero) |-> (o_right_offset == '0 && o_upaxis_y == '0
                                     && o_upaxis_offset == '0))
        else $error("zero right axis gave nonzero entries");

endmodule

bind look_at_view_matrix lad_chk u_lad_chk (.*);

`default_nettype wire

// ----- test/tb_look_at_view_matrix.sv -----
// ============================================================================
// tb_look_at_view_matrix
// Self-checking bench for the right-handed look-at view matrix pipeline.
// Requests carrying eye, target and up hint go in through the valid/stall
// input channel. The bench predicts each matrix in fixed point and compares
// all twelve entries of every result, in order, under varied idling.
// ============================================================================
`timescale 1ns / 100ps

module tb_look_at_view_matrix;
    import lad_pkg::Q_W;

    localparam int TAIL_CYCLES  = 400;   // well past the pipeline depth
    localparam int WATCHDOG_MAX = 20000; // idle cycles tolerated before giving up

    typedef logic signed [2:0][63:0]     vec3_t;
    typedef logic signed [11:0][Q_W-1:0] matrix_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [Q_W-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [Q_W-1:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic signed [Q_W-1:0] i_up_hint_x = '0, i_up_hint_y = '0, i_up_hint_z = '0;
    logic signed [Q_W-1:0] o_right_x, o_right_y, o_right_z, o_right_offset;
    logic signed [Q_W-1:0] o_upaxis_x, o_upaxis_y, o_upaxis_z, o_upaxis_offset;
    logic signed [Q_W-1:0] o_back_x, o_back_y, o_back_z, o_front_offset;

    // Matrices predicted for accepted requests, oldest first.
    matrix_t pending_views[$];
    int      error_count = 0;
    int      requests_sent = 0;
    int      results_checked = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      quiet_cycles = 0;

    string entry_name[12] = '{"right_x", "right_y", "right_z", "right_offset",
                              "upaxis_x", "upaxis_y", "upaxis_z", "upaxis_offset",
                              "back_x", "back_y", "back_z", "front_offset"};

    look_at_view_matrix DUT (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor. All arithmetic is carried in 64 bits, which holds every
    // intermediate exactly at these input widths.
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Scales a vector into [2^29, 2^30) by its largest magnitude, then
    // divides each component by the truncated length with rounding half
    // away from zero. A zero vector stays zero.
    function automatic vec3_t unit_vector(input vec3_t a);
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned peak, sum, len, q;
        longint          comp;
        vec3_t           o;
        peak = 0;
        sum = 0;
        o = '0;
        for (int i = 0; i < 3; i++) begin
            comp = a[i];
            neg[i] = comp < 0;
            mag[i] = neg[i] ? -comp : comp;
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) return o;
        while (peak >= 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            peak = peak >> 1;
        end
        while (peak < 64'h2000_0000) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            peak = peak << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = int_sqrt(sum);
        if (len == 0) return o;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 16) + (len >> 1)) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
        vec3_t o;
        o[0] = $signed(a[1]) * $signed(b[2]) - $signed(a[2]) * $signed(b[1]);
        o[1] = $signed(a[2]) * $signed(b[0]) - $signed(a[0]) * $signed(b[2]);
        o[2] = $signed(a[0]) * $signed(b[1]) - $signed(a[1]) * $signed(b[0]);
        return o;
    endfunction

    // Dot product with the eye, rounded from Q32.32 to Q16.16 half away
    // from zero and clamped to the 32-bit signed range.
    function automatic logic signed [Q_W-1:0] eye_offset(input vec3_t axis, input vec3_t eye,
                                                         input bit negate);
        longint          s, v;
        longint unsigned mag, r;
        s = 0;
        for (int i = 0; i < 3; i++) s = s + $signed(axis[i]) * $signed(eye[i]);
        if (negate) s = -s;
        mag = (s < 0) ? -s : s;
        r = (mag + 64'h8000) >> 16;
        v = (s < 0) ? -longint'(r) : longint'(r);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[Q_W-1:0];
    endfunction

    function automatic matrix_t view_matrix(input vec3_t eye, input vec3_t tgt,
                                            input vec3_t hint);
        vec3_t   diff, front, right, upaxis;
        matrix_t m;
        for (int i = 0; i < 3; i++) diff[i] = $signed(tgt[i]) - $signed(eye[i]);
        front  = unit_vector(diff);
        right  = unit_vector(cross3(front, hint));
        upaxis = unit_vector(cross3(right, front));
        for (int i = 0; i < 3; i++) begin
            m[i]     = right[i][Q_W-1:0];
            m[4 + i] = upaxis[i][Q_W-1:0];
            m[8 + i] = Q_W'(-$signed(front[i]));
        end
        m[3]  = eye_offset(right, eye, 1'b1);
        m[7]  = eye_offset(upaxis, eye, 1'b1);
        m[11] = eye_offset(front, eye, 1'b0);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at the edge where
    // the request was accepted, with i_valid still high so that a
    // following request can go out back to back.
    // ------------------------------------------------------------------
    task automatic send_camera(input logic signed [Q_W-1:0] ex, ey, ez,
                               input logic signed [Q_W-1:0] tx, ty, tz,
                               input logic signed [Q_W-1:0] hx, hy, hz);
        vec3_t eye, tgt, hint;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_eye_x <= ex;  i_eye_y <= ey;  i_eye_z <= ez;
        i_target_x <= tx;  i_target_y <= ty;  i_target_z <= tz;
        i_up_hint_x <= hx;  i_up_hint_y <= hy;  i_up_hint_z <= hz;
        do @(posedge i_clk); while (o_stall);
        eye  = {64'(ez), 64'(ey), 64'(ex)};
        tgt  = {64'(tz), 64'(ty), 64'(tx)};
        hint = {64'(hz), 64'(hy), 64'(hx)};
        pending_views.push_back(view_matrix(eye, tgt, hint));
        requests_sent++;
    endtask

    function automatic logic signed [Q_W-1:0] rand_word(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
            2:       return $signed($urandom_range(32'h0000_FFFF)) - 32'sh0000_8000;
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stalls.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        matrix_t got, want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_front_offset, o_back_z, o_back_y, o_back_x,
                       o_upaxis_offset, o_upaxis_z, o_upaxis_y, o_upaxis_x,
                       o_right_offset, o_right_z, o_right_y, o_right_x};
                if (pending_views.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end else begin
                    want = pending_views.pop_front();
                    for (int i = 0; i < 12; i++) begin
                        if (got[i] !== want[i]) begin
                            $error("%s: expected %0d, got %0d", entry_name[i],
                                   $signed(want[i]), $signed(got[i]));
                            error_count++;
                        end
                    end
                    results_checked++;
                end
            end
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    localparam logic signed [Q_W-1:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] QMIN = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] ONE  = 32'sh0001_0000;

    // Field extremes and a plain camera, including offsets that saturate.
    task automatic test_extremes();
        send_camera(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
        send_camera(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX, QMIN, QMAX);
        send_camera(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMIN, QMAX, QMIN);
        send_camera(QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, ONE, 0, 0);
        send_camera(QMAX, 0, QMIN, 0, QMAX, 0, 0, 0, QMIN);
        send_camera(-1, -1, -1, 1, 1, 1, 1, 0, 0);
        send_camera(QMAX, QMAX, 0, QMAX, QMAX - 1, 0, 0, 0, ONE);
        send_camera(QMIN, QMIN, QMIN, QMIN + 1, QMIN, QMIN, 0, QMAX, QMAX);
        send_camera(5 * ONE, 3 * ONE, -7 * ONE, 0, 0, 0, 0, ONE, 0);
    endtask

    // Target on the eye, hint parallel or antiparallel to front, zero hint.
    task automatic test_degenerate_axes();
        send_camera(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
        send_camera(QMAX, QMIN, 0, QMAX, QMIN, 0, QMAX, QMAX, QMAX);
        send_camera(0, 0, 0, 0, 3 * ONE, 0, 0, ONE, 0);
        send_camera(0, 0, 0, 0, 3 * ONE, 0, 0, -ONE, 0);
        send_camera(0, 0, 0, ONE, ONE, ONE, 2, 2, 2);
        send_camera(QMAX, QMAX, QMAX, 0, 0, 0, 0, 0, 0);
        send_camera(10, -20, 30, 11, -20, 30, 0, 0, 0);
        send_camera(0, 0, 0, 1, 0, 0, 0, 0, 1);
    endtask

    // Random cameras: full-range, moderate, tiny and extreme words in even mix,
    // with degenerate and saturating cases sprinkled in.
    task automatic test_random_cameras(input int count, input int idle_pct,
                                       input int stall_pct);
        logic signed [Q_W-1:0] e[3], t[3], h[3];
        int kind, shape;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(3);
            shape = $urandom_range(9);
            for (int i = 0; i < 3; i++) begin
                e[i] = rand_word($urandom_range(2) == 0 ? 0 : kind);
                t[i] = rand_word(kind);
                h[i] = rand_word($urandom_range(3));
            end
            if (shape == 0) begin
                t = e;
            end else if (shape == 1) begin
                // Hint along the viewing direction: the right axis vanishes.
                for (int i = 0; i < 3; i++) begin
                    t[i] = e[i] + rand_word(2) * 0 + ((i == 0) ? 3 : 0) * 32'sh100;
                    h[i] = (i == 0) ? 32'sh300 : 0;
                end
            end
            send_camera(e[0], e[1], e[2], t[0], t[1], t[2], h[0], h[1], h[2]);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_degenerate_axes();
        test_random_cameras(400, 0, 0);
        test_random_cameras(400, 75, 0);
        test_random_cameras(400, 0, 75);
        test_random_cameras(400, 19, 19);
        i_valid <= 1'b0;

        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d camera requests (extremes, degenerate axes, random mixes)",
                 requests_sent);
        $display("under four idle/stall patterns; %0d matrices compared.", results_checked);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
